// File: rtl/mbf_pkg.sv
// Shared types, constants and helper functions of the mipmap box filter chain.
// Used by every module of the block; depends on nothing else.
package mbf_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_LEVELS = 12;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int LVL_W      = 4;
  localparam int DIM_W      = 13;
  localparam int LANES      = 4;
  localparam int CH_W       = 8;
  localparam int LANE_W     = 10;
  localparam int SUM_W      = LANES * LANE_W;
  localparam int PIX_W      = LANES * CH_W;
  localparam int POS_W      = 11;
  localparam int OUT_DATA_W = 64;

  typedef enum logic {
    REG_BASE_WIDTH  = 1'b0,
    REG_BASE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SUM,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [PIX_W-1:0] pix;
    logic             last;
    logic [LVL_W-1:0] top;
  } result_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [X_W-1:0]   addr;
    logic [SUM_W-1:0] wdata;
  } ram_req_t;

  // A zero dimension acts as one, anything above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_WIDTH)) r = DIM_W'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] msb_pos(input logic [DIM_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < DIM_W; i++) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

  // Highest level whose dimensions are both nonzero, capped at the level count.
  function automatic logic [LVL_W-1:0] top_of_chain(input logic [DIM_W-1:0] w,
                                                    input logic [DIM_W-1:0] h);
    logic [LVL_W-1:0] t;
    t = msb_pos(w);
    if (msb_pos(h) < t) t = msb_pos(h);
    if (t > LVL_W'(MAX_LEVELS)) t = LVL_W'(MAX_LEVELS);
    return t;
  endfunction

  // First pair-sum entry of a level: each level takes the half left above the last.
  function automatic logic [X_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
    logic [X_W:0] full;
    full = (X_W+1)'(MAX_WIDTH) - ((X_W+1)'(MAX_WIDTH) >> lvl);
    return full[X_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] spread(input logic [PIX_W-1:0] p);
    logic [SUM_W-1:0] r;
    for (int c = 0; c < LANES; c++) begin
      r[c*LANE_W +: LANE_W] = {{(LANE_W-CH_W){1'b0}}, p[c*CH_W +: CH_W]};
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] avg_of(input logic [SUM_W-1:0] s);
    logic [PIX_W-1:0] r;
    for (int c = 0; c < LANES; c++) begin
      r[c*CH_W +: CH_W] = s[c*LANE_W + 2 +: CH_W];
    end
    return r;
  endfunction

endpackage

// File: rtl/mipmap_box_filter_chain_unit.sv
// Top level of the mipmap box filter chain: sequencer, level counters and output stage.
// Depends on mbf_pkg, mbf_lane_adder and mbf_pair_ram.
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready  | in_tdata: one base RGBA8 pixel
//  out_    | master    | out_tvalid / out_tready| out_tdata, out_tuser, out_tlast
//  cfg_    | write     | cfg_we                 | cfg_index, cfg_data
//
// With top_level zero an accepted pixel is done on acceptance. Otherwise every level visited
// takes a counter step (ST_LOOK), every produced result adds a pair-sum read (ST_SUM)
// and an emit (ST_EMIT), and after the last result ST_FLUSH hands the final one to the
// output register. Reset clears the level counters and the output stage; writing either
// register restarts the frame. A stalled output register holds the sequencer whenever a
// pending result must move into it.
module mipmap_box_filter_chain_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // red, green, blue, alpha
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_x, out_y, out_red, out_green, out_blue,
                                  // out_alpha, top_level, zero fill
  output logic [3:0]  out_tuser,  // mip_level
  output logic        out_tlast,  // last_in_run
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int X_W   = mbf_pkg::X_W;
  localparam int LVL_W = mbf_pkg::LVL_W;
  localparam int DIM_W = mbf_pkg::DIM_W;
  localparam int SUM_W = mbf_pkg::SUM_W;
  localparam int PIX_W = mbf_pkg::PIX_W;

  mbf_pkg::state_t  state_r, state_nxt;

  logic [DIM_W-1:0] bw_r, bh_r;
  logic [LVL_W-1:0] top;
  logic [X_W-1:0]   col_r [mbf_pkg::MAX_LEVELS];
  logic [X_W-1:0]   row_r [mbf_pkg::MAX_LEVELS];
  logic [PIX_W-1:0] held_r [mbf_pkg::MAX_LEVELS];
  logic [LVL_W-1:0] lvl_r;
  logic [PIX_W-1:0] pix_r;
  logic [SUM_W-1:0] pair_r;
  logic [PIX_W-1:0] avg_r;
  logic [X_W-1:0]   xs_r, ys_r;
  mbf_pkg::result_t pend_r, out_r;
  logic             pend_v_r, out_v_r;

  logic [X_W-1:0]   cur_x, cur_y, col_nxt, row_nxt;
  logic [DIM_W-1:0] cur_w, cur_h, x_inc, y_inc;
  logic             beyond_block, slot_free, in_fire, cfg_clear;
  logic             cnt_we, held_we, pair_load, avg_load, lvl_start;
  logic             step_level, out_load, out_last, pend_clear;
  logic [SUM_W-1:0] add_a, add_b, add_sum;
  mbf_pkg::ram_req_t ram_req;
  logic [SUM_W-1:0] ram_rdata;

  mbf_lane_adder u_adder (
    .add_a  (add_a),
    .add_b  (add_b),
    .add_sum(add_sum)
  );

  mbf_pair_ram u_ram (
    .clk      (clk),
    .ram_req  (ram_req),
    .ram_rdata(ram_rdata)
  );

  assign top       = mbf_pkg::top_of_chain(bw_r, bh_r);
  assign in_tready = (state_r == mbf_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_v_r || out_tready;
  assign cfg_clear = cfg_we;

  // Position bookkeeping of the level under work.
  assign cur_x   = col_r[lvl_r];
  assign cur_y   = row_r[lvl_r];
  assign cur_w   = bw_r >> lvl_r;
  assign cur_h   = bh_r >> lvl_r;
  assign x_inc   = {1'b0, cur_x} + DIM_W'(1);
  assign y_inc   = {1'b0, cur_y} + DIM_W'(1);

  always_comb begin
    col_nxt = x_inc[X_W-1:0];
    row_nxt = cur_y;
    if (x_inc >= cur_w) begin
      col_nxt = '0;
      row_nxt = (y_inc >= cur_h) ? '0 : y_inc[X_W-1:0];
    end
  end

  // An odd last column or row feeds nothing into the next level.
  assign beyond_block = ({1'b0, cur_x} >= {cur_w[DIM_W-1:1], 1'b0}) ||
                        ({1'b0, cur_y} >= {cur_h[DIM_W-1:1], 1'b0});

  always_comb begin
    state_nxt  = state_r;
    cnt_we     = 1'b0;
    held_we    = 1'b0;
    pair_load  = 1'b0;
    avg_load   = 1'b0;
    lvl_start  = 1'b0;
    step_level = 1'b0;
    out_load   = 1'b0;
    out_last   = 1'b0;
    pend_clear = 1'b0;
    add_a      = mbf_pkg::spread(held_r[lvl_r]);
    add_b      = mbf_pkg::spread(pix_r);
    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.addr  = mbf_pkg::level_base(lvl_r) + {1'b0, cur_x[X_W-1:1]};
    ram_req.wdata = add_sum;

    unique case (state_r)
      mbf_pkg::ST_IDLE: begin
        if (in_fire) begin
          lvl_start = 1'b1;
          if (top != '0) state_nxt = mbf_pkg::ST_LOOK;
        end
      end
      mbf_pkg::ST_LOOK: begin
        cnt_we = 1'b1;
        if (beyond_block) begin
          state_nxt = pend_v_r ? mbf_pkg::ST_FLUSH : mbf_pkg::ST_IDLE;
        end else if (!cur_x[0]) begin
          held_we   = 1'b1;
          state_nxt = pend_v_r ? mbf_pkg::ST_FLUSH : mbf_pkg::ST_IDLE;
        end else if (!cur_y[0]) begin
          ram_req.we = 1'b1;
          state_nxt  = pend_v_r ? mbf_pkg::ST_FLUSH : mbf_pkg::ST_IDLE;
        end else begin
          ram_req.re = 1'b1;
          pair_load  = 1'b1;
          state_nxt  = mbf_pkg::ST_SUM;
        end
      end
      mbf_pkg::ST_SUM: begin
        add_a     = ram_rdata;
        add_b     = pair_r;
        avg_load  = 1'b1;
        state_nxt = mbf_pkg::ST_EMIT;
      end
      mbf_pkg::ST_EMIT: begin
        if (!pend_v_r || slot_free) begin
          out_load   = pend_v_r;
          step_level = 1'b1;
          state_nxt  = (lvl_r + LVL_W'(1) == top) ? mbf_pkg::ST_FLUSH : mbf_pkg::ST_LOOK;
        end
      end
      mbf_pkg::ST_FLUSH: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_last   = 1'b1;
          pend_clear = 1'b1;
          state_nxt  = mbf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mbf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mbf_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= DIM_W'(mbf_pkg::MAX_WIDTH);
      bh_r <= DIM_W'(mbf_pkg::MAX_WIDTH);
    end else if (cfg_we) begin
      unique case (mbf_pkg::cfg_reg_t'(cfg_index))
        mbf_pkg::REG_BASE_WIDTH:  bw_r <= mbf_pkg::clamp_dim(cfg_data);
        mbf_pkg::REG_BASE_HEIGHT: bh_r <= mbf_pkg::clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      for (int i = 0; i < mbf_pkg::MAX_LEVELS; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
      end
    end else if (cnt_we) begin
      col_r[lvl_r] <= col_nxt;
      row_r[lvl_r] <= row_nxt;
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk) begin
    if (held_we) held_r[lvl_r] <= pix_r;
    if (pair_load) begin
      pair_r <= add_sum;
      xs_r   <= cur_x;
      ys_r   <= cur_y;
    end
    if (avg_load) avg_r <= mbf_pkg::avg_of(add_sum);
    if (lvl_start) begin
      pix_r <= in_tdata;
      lvl_r <= '0;
    end else if (step_level) begin
      pix_r <= avg_r;
      lvl_r <= lvl_r + LVL_W'(1);
    end
    if (step_level) begin
      pend_r <= {lvl_r + LVL_W'(1), xs_r[X_W-1:1], ys_r[X_W-1:1], avg_r, 1'b0, top};
    end
    if (out_load) begin
      out_r <= {pend_r.level, pend_r.x, pend_r.y, pend_r.pix, out_last, pend_r.top};
    end
  end

  // A result waits in the pending register until the next level shows whether
  // it is the last one of this pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (step_level) pend_v_r <= 1'b1;
      else if (pend_clear) pend_v_r <= 1'b0;
      if (out_load) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.level;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {6'b0, out_r.top, out_r.pix, out_r.y, out_r.x};

endmodule

// File: rtl/mbf_lane_adder.sv
// Shared four-lane adder of 10-bit channel sums, used for both pair and block sums.
// Depends on mbf_pkg.
module mbf_lane_adder (
  input  logic [mbf_pkg::SUM_W-1:0] add_a,
  input  logic [mbf_pkg::SUM_W-1:0] add_b,
  output logic [mbf_pkg::SUM_W-1:0] add_sum
);

  // Lanes never carry into each other: four channel values stay below 1024.
  always_comb begin
    for (int c = 0; c < mbf_pkg::LANES; c++) begin
      add_sum[c*mbf_pkg::LANE_W +: mbf_pkg::LANE_W] =
        add_a[c*mbf_pkg::LANE_W +: mbf_pkg::LANE_W] +
        add_b[c*mbf_pkg::LANE_W +: mbf_pkg::LANE_W];
    end
  end

endmodule

// File: rtl/mbf_pair_ram.sv
// Single-port store of column pair sums from even rows, with registered read data.
// Depends on mbf_pkg.
module mbf_pair_ram (
  input  logic                      clk,
  input  mbf_pkg::ram_req_t         ram_req,
  output logic [mbf_pkg::SUM_W-1:0] ram_rdata
);

  logic [mbf_pkg::SUM_W-1:0] mem [mbf_pkg::MAX_WIDTH];
  logic [mbf_pkg::SUM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ram_req.we) mem[ram_req.addr] <= ram_req.wdata;
    if (ram_req.re) rdata_r <= mem[ram_req.addr];
  end

  assign ram_rdata = rdata_r;

endmodule

// File: test/mipmap_box_filter_chain_unit_test.sv
// Self-checking testbench for the mipmap box filter chain: streams base pixels, predicts
// every coarser-level pixel in a local model and compares each output transaction.
// Depends on mbf_pkg and the mipmap_box_filter_chain_unit RTL.
module mipmap_box_filter_chain_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 3000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_ITEMS  = 150;

  typedef struct packed {
    logic [3:0]  level;
    logic [10:0] x;
    logic [10:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
    logic [3:0]  top;
  } mip_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;

  // Local model of the chain: registers, level counters and the stores.
  bit [12:0]   width_reg;
  bit [12:0]   height_reg;
  bit [39:0]   pair_store [mbf_pkg::MAX_WIDTH];
  bit [31:0]   held_pix [mbf_pkg::MAX_LEVELS];
  int unsigned col_pos [mbf_pkg::MAX_LEVELS];
  int unsigned row_pos [mbf_pkg::MAX_LEVELS];

  mip_result_t expected_mips[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          no_idle = 1'b0;
  bit          long_hold_req = 1'b0;
  int          hold_left = 0;
  int          rx_wait = 0;

  mipmap_box_filter_chain_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL mipmap_box_filter_chain_unit");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned bound_dim(input bit [12:0] v);
    if (v == 0) return 1;
    if (v > mbf_pkg::MAX_WIDTH) return mbf_pkg::MAX_WIDTH;
    return v;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < mbf_pkg::MAX_LEVELS; i++) begin
      col_pos[i] = 0;
      row_pos[i] = 0;
    end
  endfunction

  // Walks the pixel up the chain, one level per produced average.
  function automatic void predict_chain(input bit [31:0] pixel);
    int unsigned bw, bh, top, lvl, w, h, x, y, idx;
    bit [31:0]   pix;
    bit [39:0]   pair;
    bit [31:0]   avg;
    bit [9:0]    lane;
    bit          done;
    mip_result_t r;
    mip_result_t run[$];
    bw = bound_dim(width_reg);
    bh = bound_dim(height_reg);
    top = 0;
    while (top < mbf_pkg::MAX_LEVELS && (bw >> (top + 1)) >= 1 && (bh >> (top + 1)) >= 1)
      top++;
    pix = pixel;
    lvl = 0;
    done = 1'b0;
    while (lvl < top && !done) begin
      w = bw >> lvl;
      h = bh >> lvl;
      x = col_pos[lvl];
      y = row_pos[lvl];
      col_pos[lvl] = x + 1;
      if (col_pos[lvl] >= w) begin
        col_pos[lvl] = 0;
        row_pos[lvl] = y + 1;
        if (row_pos[lvl] >= h) row_pos[lvl] = 0;
      end
      if (x >= 2 * (w >> 1) || y >= 2 * (h >> 1)) begin
        done = 1'b1;
      end else if (x % 2 == 0) begin
        held_pix[lvl] = pix;
        done = 1'b1;
      end else begin
        for (int c = 0; c < 4; c++) begin
          pair[c*10 +: 10] = 10'(held_pix[lvl][c*8 +: 8]) + 10'(pix[c*8 +: 8]);
        end
        idx = (mbf_pkg::MAX_WIDTH - (mbf_pkg::MAX_WIDTH >> lvl) + x / 2) % mbf_pkg::MAX_WIDTH;
        if (y % 2 == 0) begin
          pair_store[idx] = pair;
          done = 1'b1;
        end else begin
          for (int c = 0; c < 4; c++) begin
            lane = pair_store[idx][c*10 +: 10] + pair[c*10 +: 10];
            avg[c*8 +: 8] = lane[9:2];
          end
          r.level = 4'(lvl + 1);
          r.x     = 11'(x / 2);
          r.y     = 11'(y / 2);
          r.red   = avg[7:0];
          r.green = avg[15:8];
          r.blue  = avg[23:16];
          r.alpha = avg[31:24];
          r.last  = 1'b0;
          r.top   = 4'(top);
          run.push_back(r);
          pix = avg;
          lvl++;
        end
      end
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_mips.push_back(run[i]);
  endfunction

  // Receiver: random stalls per result, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mip_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.level = out_tuser;
      got.x     = out_tdata[10:0];
      got.y     = out_tdata[21:11];
      got.red   = out_tdata[29:22];
      got.green = out_tdata[37:30];
      got.blue  = out_tdata[45:38];
      got.alpha = out_tdata[53:46];
      got.top   = out_tdata[57:54];
      got.last  = out_tlast;
      if (expected_mips.size() == 0) begin
        report($sformatf("unexpected result level %0d x %0d y %0d", got.level, got.x, got.y));
      end else begin
        want = expected_mips.pop_front();
        if (got.level !== want.level)
          report($sformatf("mip_level %0d, expected %0d", got.level, want.level));
        if (got.x !== want.x) report($sformatf("out_x %0d, expected %0d", got.x, want.x));
        if (got.y !== want.y) report($sformatf("out_y %0d, expected %0d", got.y, want.y));
        if (got.red !== want.red)
          report($sformatf("out_red %0h, expected %0h", got.red, want.red));
        if (got.green !== want.green)
          report($sformatf("out_green %0h, expected %0h", got.green, want.green));
        if (got.blue !== want.blue)
          report($sformatf("out_blue %0h, expected %0h", got.blue, want.blue));
        if (got.alpha !== want.alpha)
          report($sformatf("out_alpha %0h, expected %0h", got.alpha, want.alpha));
        if (got.last !== want.last)
          report($sformatf("last_in_run %0b, expected %0b", got.last, want.last));
        if (got.top !== want.top)
          report($sformatf("top_level %0d, expected %0d", got.top, want.top));
      end
      rx_wait = no_idle ? 0 : $urandom_range(0, 9);
    end
  end

  // Channels favor the extremes so that saturated sums show up often.
  function automatic bit [31:0] random_pixel();
    bit [31:0] p;
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(0, 5))
        0:       p[c*8 +: 8] = 8'h00;
        1:       p[c*8 +: 8] = 8'hff;
        default: p[c*8 +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  task automatic send_pixel(input bit [31:0] pix);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_chain(pix);
  endtask

  task automatic send_pixels(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // A pixel that yields nothing may still be in flight, so settle before going on.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_mips.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input mbf_pkg::cfg_reg_t idx, input bit [12:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == mbf_pkg::REG_BASE_WIDTH) width_reg = value;
    else height_reg = value;
    restart_frame();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(input bit [12:0] w, input bit [12:0] h);
    wait_idle();
    write_reg(mbf_pkg::REG_BASE_WIDTH, w);
    write_reg(mbf_pkg::REG_BASE_HEIGHT, h);
  endtask

  task automatic test_default_size();
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h5a5a_a5a5);
  endtask

  // Also restarts a frame halfway by rewriting a register, then wraps a full frame.
  task automatic test_two_by_two();
    set_frame(13'd2, 13'd2);
    send_pixel(32'h1234_5678);
    send_pixel(32'h8765_4321);
    wait_idle();
    write_reg(mbf_pkg::REG_BASE_WIDTH, 13'd2);
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'hffff_ffff);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0102_0304);
    send_pixel(32'h0304_0102);
    send_pixel(32'h8080_8080);
    send_pixel(32'h7f7f_7f7f);
  endtask

  task automatic test_degenerate_sizes();
    set_frame(13'd0, 13'd0);
    send_pixels(2);
    set_frame(13'd8191, 13'd1);
    send_pixels(2);
  endtask

  task automatic test_two_levels();
    set_frame(13'd4, 13'd4);
    repeat (16) send_pixel(32'hffff_ffff);
  endtask

  task automatic test_output_backpressure();
    set_frame(13'd8, 13'd8);
    no_idle = 1'b1;
    long_hold_req = 1'b1;
    send_pixels(128);
    no_idle = 1'b0;
  endtask

  task automatic test_random_frames();
    int          sent;
    int          count;
    int unsigned frame;
    bit [12:0]   dim [2];
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      for (int i = 0; i < 2; i++) begin
        case ($urandom_range(0, 9))
          0:       dim[i] = 13'd0;
          1:       dim[i] = 13'($urandom_range(4096, 8191));
          default: dim[i] = 13'($urandom_range(1, 12));
        endcase
      end
      frame = bound_dim(dim[0]) * bound_dim(dim[1]);
      // Mostly whole frames, some cut short before the next restart.
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, frame > 150 ? 150 : frame);
      else count = frame * $urandom_range(1, 2);
      if (count > 150) count = 150;
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      set_frame(dim[0], dim[1]);
      no_idle = ($urandom_range(0, 3) == 0);
      send_pixels(count);
      no_idle = 1'b0;
      sent += count;
    end
  endtask

  // The first row of the widest base level only fills the pair store.
  task automatic test_widest_rows();
    set_frame(13'd4096, 13'd2);
    send_pixels(16);
  endtask

  task automatic test_tallest_columns();
    set_frame(13'd2, 13'd8191);
    send_pixels(32);
  endtask

  task automatic test_deep_chain();
    set_frame(13'd8, 13'd8);
    send_pixels(64);
  endtask

  initial begin
    width_reg  = 13'd4096;
    height_reg = 13'd4096;
    foreach (pair_store[i]) pair_store[i] = '0;
    foreach (held_pix[i]) held_pix[i] = '0;
    restart_frame();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_size();
    test_two_by_two();
    test_degenerate_sizes();
    test_two_levels();
    test_output_backpressure();
    test_random_frames();
    test_widest_rows();
    test_tallest_columns();
    test_deep_chain();

    wait_idle();
    if (error_count == 0) begin
      $display("PASS mipmap_box_filter_chain_unit");
    end else begin
      $display("FAIL mipmap_box_filter_chain_unit");
    end
    $finish;
  end

endmodule
